// ===== design/usbf_pkg.sv =====
// Shared types and constants for the message packet framer.
// Holds request kinds, stream marks, byte-source codes and the
// command and status structs that join controller and datapath.
package usbf_pkg;

   localparam logic [1:0] KIND_BEGIN = 2'd0;
   localparam logic [1:0] KIND_BYTE  = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   localparam logic [7:0] MARK_START = 8'h3F;
   localparam logic [7:0] MARK_HASH  = 8'h23;
   localparam logic [7:0] PAD_BYTE   = 8'h00;

   localparam int HDR_BYTES = 9;
   localparam int HDR_IDX_W = 4;

   localparam logic [1:0] SEL_HDR  = 2'd0;
   localparam logic [1:0] SEL_MARK = 2'd1;
   localparam logic [1:0] SEL_PAY  = 2'd2;
   localparam logic [1:0] SEL_ZERO = 2'd3;

   typedef struct packed {
      logic                 load;
      logic                 begin_msg;
      logic                 close_msg;
      logic                 emit;
      logic                 restart;
      logic                 last;
      logic [1:0]           sel;
      logic [HDR_IDX_W-1:0] hdr_idx;
   } cmd_type;

   typedef struct packed {
      logic open;
      logic fill_full;
      logic fill_next_full;
      logic slot_free;
   } status_type;

endpackage

// ===== design/usb_message_packet_framer.sv =====
// Top level of the message packet framer: request decode and byte
// sequencing in usbf_ctrl, fields, fill count and result stage in usbf_dp.
// Depends on usbf_pkg, usbf_ctrl, usbf_dp.
//
//   channel  dir  ports                                         handshake
//   req      in   req_kind req_msg_id req_msg_size req_payload_byte  req_valid/ready
//   rsp      out  rsp_out_byte rsp_packet_end rsp_run_last       rsp_valid/ready
//
// A request is accepted while the byte sequencer in usbf_ctrl is idle; it then
// issues the result bytes in turn: 9 for a begin, 1 or 2 for a payload byte (2
// with a continuation mark) and up to PACKET_BYTES - 2 for an end, and takes no
// new request before the last. Requests that cause no result leave it idle.
// Reset clears the sequencer, the fill count, the open flag and rsp_valid.
// Low rsp_ready holds the sequencer; the next request is taken while the
// last result of the previous one still waits in the result register.
module usb_message_packet_framer #(
   parameter int PACKET_BYTES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_msg_id,
   input  logic [31:0] req_msg_size,
   input  logic [7:0]  req_payload_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_packet_end,
   output logic        rsp_run_last
);

   usbf_pkg::cmd_type    cmd;
   usbf_pkg::status_type sts;

   usbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .sts       (sts),
      .cmd       (cmd)
   );

   usbf_dp #(
      .PACKET_BYTES (PACKET_BYTES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_msg_id       (req_msg_id),
      .req_msg_size     (req_msg_size),
      .req_payload_byte (req_payload_byte),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_packet_end   (rsp_packet_end),
      .rsp_run_last     (rsp_run_last)
   );

endmodule

// ===== design/usbf_dp.sv =====
// Datapath of the message packet framer: captured request fields,
// packet fill count, open flag and the registered result stage.
// Depends on usbf_pkg.
module usbf_dp #(
   parameter int PACKET_BYTES = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [15:0]         req_msg_id,
   input  logic [31:0]         req_msg_size,
   input  logic [7:0]          req_payload_byte,
   input  usbf_pkg::cmd_type   cmd,
   output usbf_pkg::status_type sts,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_packet_end,
   output logic                rsp_run_last
);

   localparam int FILL_W = $clog2(PACKET_BYTES + 1);
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(PACKET_BYTES);

   logic [15:0]       id_ff;
   logic [31:0]       size_ff;
   logic [7:0]        pay_ff;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              open_ff, open_in;
   logic              valid_ff, valid_in;
   logic [7:0]        byte_ff;
   logic              end_ff;
   logic              last_ff;
   logic [FILL_W-1:0] fill_base;
   logic [FILL_W-1:0] fill_next;
   logic [7:0]        hdr_byte;
   logic [7:0]        emit_byte;

   assign fill_base = cmd.restart ? '0 : fill_ff;
   assign fill_next = fill_base + FILL_W'(1);

   always_comb begin
      unique case (cmd.hdr_idx)
         4'd0:    hdr_byte = usbf_pkg::MARK_START;
         4'd1:    hdr_byte = usbf_pkg::MARK_HASH;
         4'd2:    hdr_byte = usbf_pkg::MARK_HASH;
         4'd3:    hdr_byte = id_ff[15:8];
         4'd4:    hdr_byte = id_ff[7:0];
         4'd5:    hdr_byte = size_ff[31:24];
         4'd6:    hdr_byte = size_ff[23:16];
         4'd7:    hdr_byte = size_ff[15:8];
         4'd8:    hdr_byte = size_ff[7:0];
         default: hdr_byte = usbf_pkg::PAD_BYTE;
      endcase
   end

   always_comb begin
      unique case (cmd.sel)
         usbf_pkg::SEL_HDR:  emit_byte = hdr_byte;
         usbf_pkg::SEL_MARK: emit_byte = usbf_pkg::MARK_START;
         usbf_pkg::SEL_PAY:  emit_byte = pay_ff;
         default:            emit_byte = usbf_pkg::PAD_BYTE;
      endcase
   end

   always_comb begin
      fill_in = fill_ff;
      open_in = open_ff;
      if (cmd.begin_msg || cmd.close_msg) begin
         fill_in = '0;
      end else if (cmd.emit) begin
         fill_in = fill_next;
      end
      if (cmd.begin_msg) begin
         open_in = 1'b1;
      end else if (cmd.close_msg) begin
         open_in = 1'b0;
      end
      if (cmd.emit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         open_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         open_ff  <= open_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff   <= req_msg_id;
         size_ff <= req_msg_size;
         pay_ff  <= req_payload_byte;
      end
      if (cmd.emit) begin
         byte_ff <= emit_byte;
         end_ff  <= (fill_next == FILL_MAX);
         last_ff <= cmd.last;
      end
   end

   assign sts.open           = open_ff;
   assign sts.fill_full      = (fill_ff >= FILL_MAX);
   assign sts.fill_next_full = (fill_next == FILL_MAX);
   assign sts.slot_free      = !valid_ff || rsp_ready;

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_packet_end = end_ff;
   assign rsp_run_last   = last_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_MAX)
      else $error("packet fill beyond packet size");

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!valid_ff || rsp_ready))
      else $error("result emitted over a pending result");

   a_emit_open: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> open_ff)
      else $error("result emitted with no open message");

endmodule

// ===== design/usbf_ctrl.sv =====
// Controller of the message packet framer: decodes each request and
// sequences header, continuation, payload and padding bytes.
// Depends on usbf_pkg.
module usbf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_kind,
   input  usbf_pkg::status_type sts,
   output usbf_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_HDR  = 3'd1;
   localparam logic [2:0] ST_CONT = 3'd2;
   localparam logic [2:0] ST_BYTE = 3'd3;
   localparam logic [2:0] ST_PAD  = 3'd4;

   localparam logic [usbf_pkg::HDR_IDX_W-1:0] HDR_LAST =
      usbf_pkg::HDR_IDX_W'(usbf_pkg::HDR_BYTES - 1);

   logic [2:0]                        state_ff, state_in;
   logic [usbf_pkg::HDR_IDX_W-1:0]    idx_ff, idx_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               unique case (req_kind)
                  usbf_pkg::KIND_BEGIN: begin
                     if (!sts.open) begin
                        cmd.begin_msg = 1'b1;
                        idx_in        = '0;
                        state_in      = ST_HDR;
                     end
                  end
                  usbf_pkg::KIND_BYTE: begin
                     if (sts.open) begin
                        state_in = sts.fill_full ? ST_CONT : ST_BYTE;
                     end
                  end
                  usbf_pkg::KIND_END: begin
                     if (sts.open) begin
                        if (sts.fill_full) begin
                           cmd.close_msg = 1'b1;
                        end else begin
                           state_in = ST_PAD;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_HDR: begin
            if (sts.slot_free) begin
               cmd.emit    = 1'b1;
               cmd.sel     = usbf_pkg::SEL_HDR;
               cmd.hdr_idx = idx_ff;
               cmd.last    = (idx_ff == HDR_LAST);
               if (idx_ff == HDR_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_CONT: begin
            if (sts.slot_free) begin
               cmd.emit    = 1'b1;
               cmd.restart = 1'b1;
               cmd.sel     = usbf_pkg::SEL_MARK;
               state_in    = ST_BYTE;
            end
         end
         ST_BYTE: begin
            if (sts.slot_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = usbf_pkg::SEL_PAY;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            if (sts.slot_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = usbf_pkg::SEL_ZERO;
               if (sts.fill_next_full) begin
                  cmd.last      = 1'b1;
                  cmd.close_msg = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   a_hdr_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HDR) |-> (idx_ff <= HDR_LAST))
      else $error("header index past last header byte");

   a_cont_then_byte: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONT) |=> (state_ff == ST_CONT || state_ff == ST_BYTE))
      else $error("continuation mark not followed by payload byte");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.last) |=> (state_ff == ST_IDLE))
      else $error("run ended but sequencer still busy");

endmodule
